FILE: sv/tspb_pkg.sv
package tspb_pkg;

  localparam int OP_W   = 1;
  localparam int PORT_W = 3;
  localparam int ID_W   = 12;
  localparam int ACT_W  = 3;
  localparam int MASK_W = 8;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] PIU_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_PACKET = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK   = 1'b1;

  localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DUP     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BLOCKED = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

endpackage

FILE: sv/tspb_if.sv
interface tspb_in_if;
  logic                          valid;
  logic                          ready;
  logic [tspb_pkg::OP_W-1:0]     op;
  logic [tspb_pkg::PORT_W-1:0]   port;
  logic [tspb_pkg::ID_W-1:0]     packet_id;

  modport source (output valid, output op, output port, output packet_id, input ready);
  modport sink   (input valid, input op, input port, input packet_id, output ready);
endinterface

interface tspb_out_if;
  logic                          valid;
  logic                          ready;
  logic [tspb_pkg::ACT_W-1:0]    action;
  logic [tspb_pkg::MASK_W-1:0]   blocked_mask;

  modport source (output valid, output action, output blocked_mask, input ready);
  modport sink   (input valid, input action, input blocked_mask, output ready);
endinterface

interface tspb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tspb_pkg::CFG_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/traffic_share_port_blocker_top.sv
// Flood filter for a broadcast node.
// in_i  : one transaction per item; op selects packet arrival or window tick.
// out_o : exactly one result transaction per input item, in order, carrying
//         the action code and the blocked mask after the item.
// cfg_i : writes ports_in_use; always ready, write only while idle.
// A packet is accepted with a registered read of the seen map and the port
// counter; the read-modify-write then loads the result. A packet on an unused
// port and a tick with at most one port in use go straight to the result.
// An acting tick walks the n ports in use through one adder and one compare:
// a read and an add per port to sum, the limit step, a read, a multiply and a
// compare per port, then the report. One item is in work at a time.
// After reset the seen map is swept clear, one entry per cycle, through all
// 2**ID_BITS entries (4096 by default); in_i is not ready meanwhile.
// Port counters and the blocked mask clear at reset at once.
// The result sits in an output register; if the receiver stalls, the block
// holds its finished item until the register frees and takes no new item.
module traffic_share_port_blocker_top #(
  parameter int NPORTS     = 8,
  parameter int ID_BITS    = 12,
  parameter int COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tspb_in_if.sink    in_i,
  tspb_out_if.source out_o,
  tspb_cfg_if.sink   cfg_i
);
  import tspb_pkg::*;

  localparam int PIDX_W = (NPORTS > 1) ? $clog2(NPORTS) : 1;
  localparam int AW     = $clog2(NPORTS + 1);
  localparam int SUM_W  = COUNT_BITS + PIDX_W;
  localparam int PROD_W = SUM_W + 7;
  localparam int DEPTH  = 1 << ID_BITS;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PKT     = 4'd2;
  localparam logic [3:0] S_SUM_RD  = 4'd3;
  localparam logic [3:0] S_SUM_ADD = 4'd4;
  localparam logic [3:0] S_LIM     = 4'd5;
  localparam logic [3:0] S_CMP_RD  = 4'd6;
  localparam logic [3:0] S_CMP_MUL = 4'd7;
  localparam logic [3:0] S_CMP_CHK = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [ID_BITS-1:0]    clr_q, clr_d;
  logic [CFG_W-1:0]      piu_q;
  logic [PIDX_W-1:0]     i_q, i_d;
  logic [PIDX_W-1:0]     port_q, port_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [PROD_W-1:0]     lim_q, lim_d;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [NPORTS-1:0]     blocked_q, blocked_d;
  logic [NPORTS-1:0]     cnt_vld_q, cnt_vld_d;
  logic [ACT_W-1:0]      act_q, act_d;
  logic                  out_valid_q, out_valid_d;
  logic [ACT_W-1:0]      out_act_q, out_act_d;
  logic [MASK_W-1:0]     out_mask_q, out_mask_d;

  logic                  seen_mem [DEPTH];
  logic                  seen_rd_q;
  logic                  seen_re, seen_we, seen_wdata;
  logic [ID_BITS-1:0]    seen_raddr, seen_waddr;

  logic [COUNT_BITS-1:0] cnt_mem [NPORTS];
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic                  cnt_rv_q;
  logic                  cnt_re, cnt_we;
  logic [PIDX_W-1:0]     cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_eff;

  logic [AW-1:0]         active;
  logic [PIDX_W-1:0]     last;
  logic                  in_fire, out_free;

  assign active = (32'(piu_q) > NPORTS) ? AW'(NPORTS) : AW'(piu_q);
  assign last   = PIDX_W'(active - AW'(1));

  assign in_i.ready   = (state_q == S_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;
  assign cfg_i.ready  = 1'b1;

  assign out_o.valid        = out_valid_q;
  assign out_o.action       = out_act_q;
  assign out_o.blocked_mask = out_mask_q;

  assign cnt_eff = cnt_rv_q ? cnt_rd_q : '0;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    port_d      = port_q;
    id_d        = id_q;
    sum_d       = sum_q;
    lim_d       = lim_q;
    prod_d      = prod_q;
    blocked_d   = blocked_q;
    cnt_vld_d   = cnt_vld_q;
    act_d       = act_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_act_d   = out_act_q;
    out_mask_d  = out_mask_q;
    seen_re     = 1'b0;
    seen_raddr  = ID_BITS'(in_i.packet_id);
    seen_we     = 1'b0;
    seen_waddr  = id_q;
    seen_wdata  = 1'b1;
    cnt_re      = 1'b0;
    cnt_raddr   = i_q;
    cnt_we      = 1'b0;
    cnt_wdata   = (cnt_eff == '1) ? cnt_eff : cnt_eff + COUNT_BITS'(1);

    unique case (state_q)
      S_CLEAR: begin
        seen_we    = 1'b1;
        seen_waddr = clr_q;
        seen_wdata = 1'b0;
        clr_d      = clr_q + ID_BITS'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          port_d = PIDX_W'(in_i.port);
          id_d   = ID_BITS'(in_i.packet_id);
          i_d    = '0;
          sum_d  = '0;
          if (in_i.op == OP_TICK) begin
            if (32'(active) > 1) begin
              blocked_d = '0;
              state_d   = S_SUM_RD;
            end else begin
              act_d   = ACT_TICK;
              state_d = S_DONE;
            end
          end else if (32'(in_i.port) >= 32'(active)) begin
            act_d   = ACT_UNUSED;
            state_d = S_DONE;
          end else begin
            seen_re   = 1'b1;
            cnt_re    = 1'b1;
            cnt_raddr = PIDX_W'(in_i.port);
            state_d   = S_PKT;
          end
        end
      end
      S_PKT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mask_d  = MASK_W'(blocked_q);
          if (seen_rd_q) begin
            out_act_d = ACT_DUP;
          end else begin
            seen_we           = 1'b1;
            cnt_we            = 1'b1;
            cnt_vld_d[port_q] = 1'b1;
            out_act_d         = blocked_q[port_q] ? ACT_BLOCKED : ACT_FORWARD;
          end
          state_d = S_IDLE;
        end
      end
      S_SUM_RD: begin
        cnt_re  = 1'b1;
        state_d = S_SUM_ADD;
      end
      S_SUM_ADD: begin
        sum_d = sum_q + SUM_W'(cnt_eff);
        if (i_q == last) begin
          i_d     = '0;
          state_d = S_LIM;
        end else begin
          i_d     = i_q + PIDX_W'(1);
          state_d = S_SUM_RD;
        end
      end
      S_LIM: begin
        // sum * 67
        lim_d   = (PROD_W'(sum_q) << 6) + (PROD_W'(sum_q) << 1) + PROD_W'(sum_q);
        state_d = S_CMP_RD;
      end
      S_CMP_RD: begin
        cnt_re  = 1'b1;
        state_d = S_CMP_MUL;
      end
      S_CMP_MUL: begin
        // count * 100
        prod_d  = (PROD_W'(cnt_eff) << 6) + (PROD_W'(cnt_eff) << 5) + (PROD_W'(cnt_eff) << 2);
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (prod_q > lim_q) begin
          blocked_d[i_q] = 1'b1;
        end
        if (i_q == last) begin
          cnt_vld_d = '0;
          act_d     = ACT_TICK;
          state_d   = S_DONE;
        end else begin
          i_d     = i_q + PIDX_W'(1);
          state_d = S_CMP_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_act_d   = act_q;
          out_mask_d  = MASK_W'(blocked_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      piu_q       <= PIU_RESET;
      blocked_q   <= '0;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      blocked_q   <= blocked_d;
      cnt_vld_q   <= cnt_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        piu_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    port_q     <= port_d;
    id_q       <= id_d;
    sum_q      <= sum_d;
    lim_q      <= lim_d;
    prod_q     <= prod_d;
    act_q      <= act_d;
    out_act_q  <= out_act_d;
    out_mask_q <= out_mask_d;
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
    if (seen_re) begin
      seen_rd_q <= seen_mem[seen_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[port_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
      cnt_rv_q <= cnt_vld_q[cnt_raddr];
    end
  end

`ifndef SYNTH
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready)
    else $error("input accepted during seen map sweep");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && clr_q == '1) |=> (state_q == S_IDLE))
    else $error("seen map sweep did not finish");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("second item accepted while one in work");

  a_tick_clears_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP_CHK && i_q == last) |=> (cnt_vld_q == '0))
    else $error("port counts not cleared at end of window");

  a_result_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && (state_q == S_PKT || state_q == S_DONE))
      |=> $stable(out_act_q) && $stable(out_mask_q))
    else $error("pending result overwritten");
`endif

endmodule

FILE: tb/traffic_share_port_blocker_top_test.sv
`timescale 1ns / 1ps

module traffic_share_port_blocker_top_test;
  import tspb_pkg::*;

  localparam int NUM_PORTS   = 8;
  localparam int ID_SPACE    = 1 << ID_W;
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [MASK_W-1:0] mask;
  } filter_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  tspb_in_if  in_bus ();
  tspb_out_if out_bus ();
  tspb_cfg_if cfg_bus ();

  traffic_share_port_blocker_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // filter state as the block should hold it
  bit   [ID_SPACE-1:0] id_seen = '0;
  logic [31:0]         port_count [NUM_PORTS];
  logic [MASK_W-1:0]   blocked_now = '0;
  logic [CFG_W-1:0]    ports_cfg = PIU_RESET;

  filter_result_t   pending_results [$];
  logic [ID_W-1:0]  used_ids [$];

  int err_count     = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  initial begin
    for (int i = 0; i < NUM_PORTS; i++) port_count[i] = '0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic int active_ports();
    return (ports_cfg > NUM_PORTS) ? NUM_PORTS : int'(ports_cfg);
  endfunction

  function automatic filter_result_t predict_filter_result(input logic [OP_W-1:0] op,
                                                           input logic [PORT_W-1:0] port,
                                                           input logic [ID_W-1:0] pid);
    filter_result_t r;
    int n;
    logic [63:0] total;
    logic [63:0] limit;
    n = active_ports();
    if (op == OP_TICK) begin
      if (n > 1) begin
        total = '0;
        for (int i = 0; i < n; i++) total += 64'(port_count[i]);
        limit = total * 64'd67;
        blocked_now = '0;
        for (int i = 0; i < n; i++) begin
          if (64'(port_count[i]) * 64'd100 > limit) blocked_now[i] = 1'b1;
        end
        for (int i = 0; i < NUM_PORTS; i++) port_count[i] = '0;
      end
      r.action = ACT_TICK;
    end else if (int'(port) >= n) begin
      r.action = ACT_UNUSED;
    end else if (id_seen[pid]) begin
      r.action = ACT_DUP;
    end else begin
      id_seen[pid] = 1'b1;
      if (port_count[port] != '1) port_count[port]++;
      r.action = blocked_now[port] ? ACT_BLOCKED : ACT_FORWARD;
    end
    r.mask = blocked_now;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] v;
    v = $urandom_range(ID_SPACE - 1);
    while (id_seen[v]) v = $urandom_range(ID_SPACE - 1);
    return v;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                           input logic [ID_W-1:0] pid);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_bus.valid     <= 1'b1;
    in_bus.op        <= op;
    in_bus.port      <= port;
    in_bus.packet_id <= pid;
    @(posedge clk_i);
    while (in_bus.ready !== 1'b1) @(posedge clk_i);
    pending_results.push_back(predict_filter_result(op, port, pid));
  endtask

  task automatic send_packet(input logic [PORT_W-1:0] port, input logic [ID_W-1:0] pid);
    send_item(OP_PACKET, port, pid);
    used_ids.push_back(pid);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, '0, '0);
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ports_in_use(input logic [CFG_W-1:0] v);
    wait_for_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk_i);
    while (cfg_bus.ready !== 1'b1) @(posedge clk_i);
    ports_cfg = v;
    cfg_bus.valid <= 1'b0;
  endtask

  // result checking
  always @(posedge clk_i) begin
    filter_result_t want;
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction action %0d mask %02h",
                                  out_bus.action, out_bus.blocked_mask));
      end else begin
        want = pending_results.pop_front();
        if (out_bus.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", out_bus.action, want.action));
        if (out_bus.blocked_mask !== want.mask)
          report_mismatch($sformatf("blocked_mask %02h, want %02h",
                                    out_bus.blocked_mask, want.mask));
      end
    end
  end

  // receiver: random stalls plus a counted hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("traffic_share_port_blocker_top_test: errors");
      $finish;
    end
  end

  task automatic test_forward_and_duplicates();
    send_packet(3'd0, 12'h000);
    send_packet(3'd7, 12'hfff);
    send_packet(3'd0, 12'h000);
    send_packet(3'b101, 12'h555);
    send_packet(3'b010, 12'haaa);
    send_tick();
    send_tick();   // no traffic in window
  endtask

  task automatic test_window_blocking();
    for (int i = 0; i < 5; i++) send_packet(3'd3, 12'd100 + ID_W'(i));
    send_packet(3'd6, 12'd200);
    send_tick();
    send_packet(3'd3, 12'd105);
    send_packet(3'd6, 12'd201);
    send_packet(3'd3, 12'd106);
    send_tick();   // two of three: just under the share limit
  endtask

  task automatic test_port_config_edges();
    for (int i = 0; i < 3; i++) send_packet(3'd7, 12'd300 + ID_W'(i));
    send_tick();
    write_ports_in_use(4'd2);
    send_packet(3'd7, 12'd303);   // stale blocked bit stays visible
    send_packet(3'd1, 12'd304);
    write_ports_in_use(4'd1);
    send_tick();
    send_packet(3'd1, 12'd305);
    send_packet(3'd0, 12'd305);
    write_ports_in_use(4'd0);
    send_packet(3'd0, 12'd306);
    send_tick();
    write_ports_in_use(4'd2);
    send_tick();
    write_ports_in_use(4'd15);
    send_packet(3'd7, 12'd307);
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    int n;
    int len;
    int heavy;
    int heavy_pct;
    int r;
    logic [PORT_W-1:0] port;
    logic [ID_W-1:0] pid;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(99) < 80) write_ports_in_use(CFG_W'($urandom_range(2, 8)));
        else write_ports_in_use(CFG_W'($urandom_range(15)));
      end
      n         = active_ports();
      heavy     = (n > 0) ? $urandom_range(n - 1) : 0;
      heavy_pct = $urandom_range(40, 100);
      len       = $urandom_range(1, 14);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          send_item(OP_W'($urandom_range(1)), PORT_W'($urandom_range(7)),
                    ID_W'($urandom_range(ID_SPACE - 1)));
        end else begin
          port = ($urandom_range(99) < heavy_pct) ? PORT_W'(heavy) : PORT_W'($urandom_range(7));
          if (r < 20 && used_ids.size() > 0) pid = used_ids[$urandom_range(used_ids.size() - 1)];
          else pid = fresh_id();
          send_packet(port, pid);
        end
        sent++;
      end
      send_tick();
      sent++;
    end
  endtask

  task automatic test_output_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_ports_in_use(4'd4);
    @(negedge clk_i);
    stall_left = HOLD_CYCLES;
    for (int i = 0; i < 60; i++) begin
      if (i % 8 == 7) send_tick();
      else send_packet(($urandom_range(99) < 75) ? 3'd0 : PORT_W'($urandom_range(3)), fresh_id());
    end
    wait_for_results();
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.op        = OP_PACKET;
    in_bus.port      = '0;
    in_bus.packet_id = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = PIU_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_forward_and_duplicates();
    test_window_blocking();
    test_port_config_edges();
    test_random_traffic(0, 0, 260);
    test_random_traffic(81, 0, 260);
    test_random_traffic(0, 81, 260);
    test_random_traffic(21, 21, 260);
    test_output_backpressure();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("traffic_share_port_blocker_top_test: clean");
    end else begin
      $display("traffic_share_port_blocker_top_test: errors");
    end
    $finish;
  end

endmodule
